// ===== rtl/kpa_pkg.sv =====
package kpa_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_KEYS_IN_USE = '0;

    typedef enum logic [2:0] {
        ACT_ALLOC = 3'd0,
        ACT_FREE  = 3'd1,
        ACT_SET   = 3'd2,
        ACT_GET   = 3'd3,
        ACT_CHECK = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_SLOT  = 2'd1,
        STS_BAD_SLOT = 2'd2,
        STS_BAD_KEY  = 2'd3
    } t_status;

endpackage

// ===== rtl/kpa_ram.sv =====
module kpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kpa_cfg.sv =====
module kpa_cfg #(
    parameter int KIU_W = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kpa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [kpa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [kpa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [KIU_W-1:0]                o_keys_in_use
);

    import kpa_pkg::*;

    logic [KIU_W-1:0] r_keys_in_use;
    logic             sel_keys;

    assign sel_keys = (paddr[APB_ADDR_W-1:2] == REG_KEYS_IN_USE);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys_in_use <= '0;
        end else if (psel && penable && pwrite && pready && sel_keys) begin
            r_keys_in_use <= pwdata[KIU_W-1:0];
        end
    end

    assign prdata        = sel_keys ? APB_DATA_W'(r_keys_in_use) : '0;
    assign o_keys_in_use = r_keys_in_use;

endmodule

// ===== rtl/keyset_pool_allocator.sv =====
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               i_action, i_slot_id, i_key_id, i_write_value
// result    out        o_result_valid (strobe)   o_status, o_granted_slot, o_read_value, o_slot_valid
// config    in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// Free, set, get and check issue the synchronous read of the link and byte memories in
// S_IDLE, then decide, write back and register the result in S_EXEC.
// Allocate grants a slot in S_EXEC if one is free and then clears it through the byte memory
// write port, one key per cycle; with an empty free list it first builds links for up to GROUP_SIZE fresh slots.
// Reset is synchronous; no clearing pass follows it. The receiver cannot stall results.
module keyset_pool_allocator #(
    parameter int NUM_SLOTS  = 64,
    parameter int NUM_KEYS   = 64,
    parameter int GROUP_SIZE = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_action,
    input  logic [$clog2(NUM_SLOTS)-1:0]    i_slot_id,
    input  logic [$clog2(NUM_KEYS)-1:0]     i_key_id,
    input  logic [7:0]                      i_write_value,
    output logic                            o_result_valid,
    output logic [1:0]                      o_status,
    output logic [$clog2(NUM_SLOTS)-1:0]    o_granted_slot,
    output logic [7:0]                      o_read_value,
    output logic                            o_slot_valid,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kpa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [kpa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [kpa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import kpa_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int KEY_W  = $clog2(NUM_KEYS);
    localparam int KIU_W  = KEY_W + 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int GROW_W = $clog2(GROUP_SIZE + 1);
    localparam int LINK_W = CNT_W + 1;
    localparam int VAL_AW = SLOT_W + KEY_W;
    localparam logic [CNT_W-1:0] EMPTY    = CNT_W'(NUM_SLOTS);
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_GREAD,
        S_EXEC,
        S_CLEAR
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_created, n_created;
    logic [GROW_W-1:0] r_grow_left, n_grow_left;
    logic [KEY_W-1:0]  r_clr_key, n_clr_key;
    logic [2:0]        r_action, n_action;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [7:0]        r_wval, n_wval;
    logic              r_result_valid, n_result_valid;
    logic [1:0]        r_status, n_status;
    logic [SLOT_W-1:0] r_granted, n_granted;
    logic [7:0]        r_read, n_read;
    logic              r_valid, n_valid;

    logic [KIU_W-1:0]  keys_in_use;
    logic [CNT_W-1:0]  grow_rem;
    logic              slot_live;
    logic              key_ok;

    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic [SLOT_W-1:0] link_raddr;
    logic [LINK_W-1:0] link_rdata;
    logic              val_we;
    logic [VAL_AW-1:0] val_waddr;
    logic [7:0]        val_wdata;
    logic [VAL_AW-1:0] val_raddr;
    logic [7:0]        val_rdata;

    kpa_cfg #(
        .KIU_W(KIU_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_keys_in_use(keys_in_use)
    );

    kpa_ram #(
        .WIDTH(LINK_W),
        .DEPTH(2 ** SLOT_W)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(link_raddr),
        .o_rdata(link_rdata)
    );

    kpa_ram #(
        .WIDTH(8),
        .DEPTH(2 ** VAL_AW)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(val_wdata),
        .i_raddr(val_raddr),
        .o_rdata(val_rdata)
    );

    assign busy      = (r_state != S_IDLE);
    assign grow_rem  = EMPTY - r_created;
    assign slot_live = (CNT_W'(r_slot) < r_created) && link_rdata[LINK_W-1];
    assign key_ok    = (KIU_W'(r_key) < keys_in_use) && (32'(r_key) < NUM_KEYS);
    assign val_raddr = {i_slot_id, i_key_id};

    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_created      = r_created;
        n_grow_left    = r_grow_left;
        n_clr_key      = r_clr_key;
        n_action       = r_action;
        n_slot         = r_slot;
        n_key          = r_key;
        n_wval         = r_wval;
        n_result_valid = 1'b0;
        n_status       = r_status;
        n_granted      = r_granted;
        n_read         = r_read;
        n_valid        = r_valid;
        link_we        = 1'b0;
        link_waddr     = r_head[SLOT_W-1:0];
        link_wdata     = '0;
        link_raddr     = r_head[SLOT_W-1:0];
        val_we         = 1'b0;
        val_waddr      = {r_slot, r_key};
        val_wdata      = r_wval;

        case (r_state)
            S_IDLE: begin
                if (i_action != ACT_ALLOC) begin
                    link_raddr = i_slot_id;
                end
                if (start) begin
                    n_action = i_action;
                    n_slot   = i_slot_id;
                    n_key    = i_key_id;
                    n_wval   = i_write_value;
                    if (i_action == ACT_ALLOC && r_head == EMPTY && r_created != EMPTY) begin
                        n_grow_left = (32'(grow_rem) > GROUP_SIZE) ?
                                      GROW_W'(GROUP_SIZE) : GROW_W'(grow_rem);
                        n_state     = S_GROW;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_GROW: begin
                // push fresh slots in ascending order
                link_we     = 1'b1;
                link_waddr  = r_created[SLOT_W-1:0];
                link_wdata  = {1'b0, r_head};
                n_head      = r_created;
                n_created   = r_created + CNT_W'(1);
                n_grow_left = r_grow_left - GROW_W'(1);
                if (r_grow_left == GROW_W'(1)) begin
                    n_state = S_GREAD;
                end
            end
            S_GREAD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_result_valid = 1'b1;
                n_status       = STS_OK;
                n_granted      = '0;
                n_read         = '0;
                n_valid        = 1'b0;
                n_state        = S_IDLE;
                case (r_action)
                    ACT_ALLOC: begin
                        if (r_head == EMPTY) begin
                            n_status = STS_NO_SLOT;
                        end else begin
                            n_granted  = r_head[SLOT_W-1:0];
                            link_we    = 1'b1;
                            link_wdata = {1'b1, link_rdata[CNT_W-1:0]};
                            n_head     = link_rdata[CNT_W-1:0];
                            n_slot     = r_head[SLOT_W-1:0];
                            n_clr_key  = '0;
                            n_state    = S_CLEAR;
                        end
                    end
                    ACT_FREE: begin
                        if (!slot_live) begin
                            n_status = STS_BAD_SLOT;
                        end else begin
                            link_we    = 1'b1;
                            link_waddr = r_slot;
                            link_wdata = {1'b0, r_head};
                            n_head     = CNT_W'(r_slot);
                        end
                    end
                    ACT_SET, ACT_GET: begin
                        if (!slot_live) begin
                            n_status = STS_BAD_SLOT;
                        end else if (!key_ok) begin
                            n_status = STS_BAD_KEY;
                        end else if (r_action == ACT_SET) begin
                            val_we = 1'b1;
                        end else begin
                            n_read = val_rdata;
                        end
                    end
                    ACT_CHECK: begin
                        n_valid = slot_live;
                    end
                    default: begin
                    end
                endcase
            end
            S_CLEAR: begin
                val_we    = 1'b1;
                val_waddr = {r_slot, r_clr_key};
                val_wdata = '0;
                n_clr_key = r_clr_key + KEY_W'(1);
                if (r_clr_key == LAST_KEY) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_slot    <= n_slot;
        r_key     <= n_key;
        r_wval    <= n_wval;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_read    <= n_read;
        r_valid   <= n_valid;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_head         <= EMPTY;
            r_created      <= '0;
            r_grow_left    <= '0;
            r_clr_key      <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_head         <= n_head;
            r_created      <= n_created;
            r_grow_left    <= n_grow_left;
            r_clr_key      <= n_clr_key;
            r_result_valid <= n_result_valid;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_status       = r_status;
    assign o_granted_slot = r_granted;
    assign o_read_value   = r_read;
    assign o_slot_valid   = r_valid;

    a_exec_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_result_valid)
        else $error("decision cycle produced no result beat");

    a_beat_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_EXEC))
        else $error("result beat without decision cycle");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= EMPTY) && (r_created <= EMPTY))
        else $error("free list head or created count out of range");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != STS_OK) |->
        (o_granted_slot == '0 && o_read_value == '0 && !o_slot_valid))
        else $error("failed beat carries data");

endmodule
